/* sv/drsa_pkg.sv */
// drsa_pkg: shared codes and control/status structs for the deferred release slot allocator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package drsa_pkg;

   // fixed field and register widths
   localparam int FUNC_W     = 2;
   localparam int SLOT_W     = 8;
   localparam int FRAME_W    = 2;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 9;
   localparam int FIF_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FRAME = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_FLIGHT = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic walk_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic walk_start;
      logic walk_last;
   } dp_status_type;

endpackage

/* sv/drsa_ctrl.sv */
// drsa_ctrl: sequencing state machine for the slot allocator
// depends on drsa_pkg; drives drsa_datapath through ctl_cmd_type
`timescale 1ns / 1ps

module drsa_ctrl import drsa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type stat,
   output ctl_cmd_type   cmd,
   output logic          busy,
   output logic          rsp_valid
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.walk_start) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_WALK: begin
            if (stat.walk_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // next request may be taken while the response is shown
            if (start) begin
               state_in = ST_EXEC;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
         end
         ST_EXEC: begin
            busy        = 1'b1;
            cmd.execute = 1'b1;
         end
         ST_WALK: begin
            busy          = 1'b1;
            cmd.walk_step = 1'b1;
         end
         ST_RESP: begin
            rsp_valid   = 1'b1;
            cmd.capture = start;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* sv/drsa_datapath.sv */
// drsa_datapath: free stack, pending lists, config registers and response registers
// depends on drsa_pkg; sequenced by drsa_ctrl
`timescale 1ns / 1ps

module drsa_datapath import drsa_pkg::*; #(
   parameter int SLOTS      = 256,
   parameter int MAX_FRAMES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           cmd,
   output dp_status_type         stat,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [SLOT_W-1:0]     req_slot_index,
   input  logic [FRAME_W-1:0]    req_frame,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_W-1:0]     rsp_granted_slot,
   output logic [COUNT_W-1:0]    rsp_free_count
);

   localparam int SC_MAX     = (SLOTS < 511) ? SLOTS : 511;
   localparam int SC_RST     = (SLOTS < 256) ? SLOTS : 256;
   localparam int FIF_RST    = (MAX_FRAMES < 2) ? MAX_FRAMES : 2;
   localparam int DW         = $clog2(SC_MAX + 1);
   localparam int SPW        = $clog2(SC_MAX);
   localparam int LINK_DEPTH = (SLOTS < 256) ? SLOTS : 256;
   localparam int LAW        = $clog2(LINK_DEPTH);
   localparam int CW         = $clog2(SLOTS + 1);
   localparam int FW         = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

   // configuration
   logic [COUNT_W-1:0] sc_ff;
   logic [FIF_W-1:0]   fif_ff;
   logic [COUNT_W-1:0] sc_wr;
   logic [FIF_W-1:0]   fif_wr;
   logic               reinit;
   logic [DW-1:0]      reinit_depth;

   // captured request
   logic [FUNC_W-1:0]  func_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [FRAME_W-1:0] frame_ff;

   // free stack
   logic [SLOT_W-1:0] stack_mem [SC_MAX];
   logic [DW-1:0]     depth_ff;
   logic [DW-1:0]     lwm_ff;
   logic [DW-1:0]     pop_depth;
   logic [SPW-1:0]    pop_pos;
   logic [SPW-1:0]    push_pos;
   logic [SLOT_W-1:0] stack_rd_ff;

   // pending lists
   logic [LAW-1:0] link_mem [LINK_DEPTH];
   logic [LAW-1:0] head_ff  [MAX_FRAMES];
   logic [LAW-1:0] tail_ff  [MAX_FRAMES];
   logic [CW-1:0]  count_ff [MAX_FRAMES];
   logic [LAW-1:0] walk_cur_ff;
   logic [CW-1:0]  remain_ff;

   // response
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic                pop_ok_ff;
   logic                pop_use_init_ff;
   logic [SLOT_W-1:0]   pop_init_ff;

   logic [FW-1:0]  fidx;
   logic [CW-1:0]  sel_count;
   logic           frame_ok;
   logic           slot_ok;
   logic           is_alloc;
   logic           is_release;
   logic           is_acquire;
   logic           alloc_ok;
   logic           release_ok;
   logic           acquire_ok;
   logic           push_en;

   // config clamping
   always_comb begin
      sc_wr = csr_wdata[COUNT_W-1:0];
      if (sc_wr == '0) begin
         sc_wr = COUNT_W'(1);
      end else if (sc_wr > COUNT_W'(SC_MAX)) begin
         sc_wr = COUNT_W'(SC_MAX);
      end
      fif_wr = csr_wdata[FIF_W-1:0];
      if (fif_wr == '0) begin
         fif_wr = FIF_W'(1);
      end else if (int'(fif_wr) > MAX_FRAMES) begin
         fif_wr = FIF_W'(MAX_FRAMES);
      end
   end

   assign reinit = csr_we &&
                   (csr_index == CSR_SLOT_COUNT || csr_index == CSR_FRAMES_IN_FLIGHT);
   assign reinit_depth = (csr_index == CSR_SLOT_COUNT) ? DW'(sc_wr) : DW'(sc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff  <= COUNT_W'(SC_RST);
         fif_ff <= FIF_W'(FIF_RST);
      end else if (csr_we && csr_index == CSR_SLOT_COUNT) begin
         sc_ff <= sc_wr;
      end else if (csr_we && csr_index == CSR_FRAMES_IN_FLIGHT) begin
         fif_ff <= fif_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         slot_ff  <= req_slot_index;
         frame_ff <= req_frame;
      end
   end

   // decode of the captured request
   assign fidx       = FW'(frame_ff);
   assign sel_count  = count_ff[fidx];
   assign frame_ok   = {1'b0, frame_ff} < fif_ff;
   assign slot_ok    = {1'b0, slot_ff} < sc_ff;
   assign is_alloc   = func_ff == FUNC_ALLOC;
   assign is_release = func_ff == FUNC_RELEASE;
   assign is_acquire = func_ff == FUNC_ACQUIRE;

   assign alloc_ok   = cmd.execute && is_alloc && depth_ff != '0;
   assign release_ok = cmd.execute && is_release && slot_ok && frame_ok &&
                       sel_count < CW'(SLOTS);
   assign acquire_ok = cmd.execute && is_acquire && frame_ok;
   assign push_en    = cmd.walk_step && COUNT_W'(depth_ff) < sc_ff;

   assign pop_depth = depth_ff - DW'(1);
   assign pop_pos   = pop_depth[SPW-1:0];
   assign push_pos  = depth_ff[SPW-1:0];

   assign stat.walk_start = is_acquire && frame_ok && sel_count != '0;
   assign stat.walk_last  = remain_ff == CW'(1);

   // stack depth and low-water mark; positions below the mark still hold init order
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DW'(SC_RST);
         lwm_ff   <= DW'(SC_RST);
      end else if (reinit) begin
         depth_ff <= reinit_depth;
         lwm_ff   <= reinit_depth;
      end else if (alloc_ok) begin
         depth_ff <= pop_depth;
         if (pop_depth < lwm_ff) begin
            lwm_ff <= pop_depth;
         end
      end else if (push_en) begin
         depth_ff <= depth_ff + DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[push_pos] <= SLOT_W'(walk_cur_ff);
      end
      if (alloc_ok) begin
         stack_rd_ff <= stack_mem[pop_pos];
      end
   end

   // pending list counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_FRAMES; i++) begin
            count_ff[i] <= '0;
         end
      end else if (reinit) begin
         for (int i = 0; i < MAX_FRAMES; i++) begin
            count_ff[i] <= '0;
         end
      end else if (release_ok) begin
         count_ff[fidx] <= sel_count + CW'(1);
      end else if (acquire_ok) begin
         count_ff[fidx] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (release_ok) begin
         if (sel_count == '0) begin
            head_ff[fidx] <= LAW'(slot_ff);
         end
         tail_ff[fidx] <= LAW'(slot_ff);
      end
   end

   // link memory; walk cursor is its registered read port
   always_ff @(posedge clock) begin
      if (release_ok && sel_count != '0) begin
         link_mem[tail_ff[fidx]] <= LAW'(slot_ff);
      end
      if (acquire_ok) begin
         walk_cur_ff <= head_ff[fidx];
      end else if (cmd.walk_step) begin
         walk_cur_ff <= link_mem[walk_cur_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else if (acquire_ok) begin
         remain_ff <= sel_count;
      end else if (cmd.walk_step) begin
         remain_ff <= remain_ff - CW'(1);
      end
   end

   always_comb begin
      status_in = STATUS_OK;
      if (is_alloc) begin
         if (depth_ff == '0) begin
            status_in = STATUS_EMPTY;
         end
      end else if (is_release) begin
         if (!slot_ok) begin
            status_in = STATUS_BAD_SLOT;
         end else if (!frame_ok) begin
            status_in = STATUS_BAD_FRAME;
         end
      end else if (is_acquire) begin
         if (!frame_ok) begin
            status_in = STATUS_BAD_FRAME;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff       <= status_in;
         pop_ok_ff       <= alloc_ok;
         pop_use_init_ff <= pop_depth < lwm_ff;
         pop_init_ff     <= SLOT_W'(sc_ff - COUNT_W'(depth_ff));
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_granted_slot = !pop_ok_ff      ? '0 :
                             pop_use_init_ff ? pop_init_ff : stack_rd_ff;
   assign rsp_free_count   = COUNT_W'(depth_ff);

endmodule

/* sv/deferred_release_slot_allocator.sv */
// allocate, release and rejected items go from the accept through ST_EXEC to ST_RESP, which strobes rsp_valid
// frame acquired walks its pending list one entry per cycle in ST_WALK, between ST_EXEC and ST_RESP
// a new item can be taken while the response is shown, as busy drops then, but not while busy
// the walk rate is set by the single registered read port of the link memory
// reset (synchronous): slot_count = min(SLOTS,256), frames_in_flight = min(MAX_FRAMES,2), stack full, lists empty
// no clearing pass: a low-water mark stands in for the initial stack contents
`timescale 1ns / 1ps

module deferred_release_slot_allocator import drsa_pkg::*; #(
   parameter int SLOTS      = 256,
   parameter int MAX_FRAMES = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [SLOT_W-1:0]     req_slot_index,
   input  logic [FRAME_W-1:0]    req_frame,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_W-1:0]     rsp_granted_slot,
   output logic [COUNT_W-1:0]    rsp_free_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctl_cmd_type   cmd;
   dp_status_type stat;
   logic          csr_we;

   assign csr_ready = !busy;
   assign csr_we    = csr_valid && csr_ready;

   drsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   drsa_datapath #(
      .SLOTS      (SLOTS),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_slot_index   (req_slot_index),
      .req_frame        (req_frame),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_free_count   (rsp_free_count)
   );

endmodule

/* sv/drsa_checker.sv */
// drsa_checker: port-level assertions for the slot allocator, bound to the top level
// depends on drsa_pkg and deferred_release_slot_allocator
`timescale 1ns / 1ps

module drsa_checker import drsa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [SLOT_W-1:0]     rsp_granted_slot,
   input logic [COUNT_W-1:0]    rsp_free_count,
   input logic                  csr_valid,
   input logic                  csr_ready
);

   // an accepted request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // a response is never shown while a request is still in work
   assert property (@(posedge clock) disable iff (reset) !(rsp_valid && busy))
      else $error("response strobe while busy");

   // a nonzero granted slot comes only with an ok status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted_slot != '0 |-> rsp_status == STATUS_OK)
      else $error("nonzero granted slot without ok status");

   // exhaustion is reported only when the stack is empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_free_count == '0)
      else $error("empty status with free slots left");

   // register writes only land between requests
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !busy)
      else $error("register write transfer while busy");

endmodule

bind deferred_release_slot_allocator drsa_checker u_drsa_checker (.*);
